### rtl/fsa_pkg.sv
// Package for the fixed step accumulator: widths, register indexes and shared structs.
`timescale 1ns / 1ps

package fsa_pkg;

    // Field widths fixed by the interface
    localparam int FRAME_W   = 32;
    localparam int STEP_W    = 32;
    localparam int MAXS_W    = 8;
    localparam int STEPS_W   = 8;
    localparam int BLEND_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // Datapath sizing
    localparam int TIME_W    = 32;   // accumulator width, 16..48
    localparam int FRAC_W    = 16;   // fraction bits, 8..24
    localparam int SUM_W     = ((TIME_W > FRAME_W) ? TIME_W : FRAME_W) + 1;
    localparam int DIV_STEPS = TIME_W + FRAC_W;
    localparam int QUOT_W    = TIME_W + FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0] DEFAULT_STEP = STEP_W'(1092);
    localparam logic [MAXS_W-1:0] DEFAULT_MAXS = MAXS_W'(1);
    localparam logic [TIME_W-1:0] ACC_MAX      = {TIME_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS   = CFG_IDX_W'(1);

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/fsa_cfg_regs.sv
// Configuration registers with zero-value fallbacks for step length and step limit.
`timescale 1ns / 1ps

module fsa_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsa_pkg::CFG_DAT_W-1:0]  cfg_data,
    output logic [fsa_pkg::STEP_W-1:0]     step_eff,
    output logic [fsa_pkg::MAXS_W-1:0]     limit_eff
);

    logic [fsa_pkg::STEP_W-1:0] step_reg;
    logic [fsa_pkg::MAXS_W-1:0] maxs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= fsa_pkg::DEFAULT_STEP;
            maxs_reg <= fsa_pkg::DEFAULT_MAXS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fsa_pkg::REG_STEP_LENGTH: step_reg <= fsa_pkg::STEP_W'(cfg_data);
                fsa_pkg::REG_MAX_STEPS:   maxs_reg <= fsa_pkg::MAXS_W'(cfg_data);
                default:                  ;  // unmapped index, dropped
            endcase
        end
    end

    assign step_eff  = (step_reg != '0) ? step_reg : fsa_pkg::DEFAULT_STEP;
    assign limit_eff = (maxs_reg != '0) ? maxs_reg : fsa_pkg::MAXS_W'(1);

endmodule

### rtl/fsa_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, int_rem tapped after TIME_W bits.
`timescale 1ns / 1ps

module fsa_serial_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsa_pkg::div_ctrl_t           ctrl,
    input  logic [fsa_pkg::TIME_W-1:0]   dividend,
    input  logic [fsa_pkg::STEP_W-1:0]   divisor,
    output fsa_pkg::div_stat_t           stat,
    output logic [fsa_pkg::QUOT_W-1:0]   quotient,
    output logic [fsa_pkg::STEP_W-1:0]   int_rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [fsa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [fsa_pkg::QUOT_W-1:0]    dvd_reg, dvd_next;      // dividend out top, quotient in bottom
    logic [fsa_pkg::STEP_W-1:0]    rem_reg, rem_next;
    logic [fsa_pkg::STEP_W-1:0]    irem_reg, irem_next;
    logic [fsa_pkg::STEP_W:0]      rem_shift;
    logic [fsa_pkg::STEP_W:0]      rem_diff;
    logic                          qbit;

    assign rem_shift = {rem_reg, dvd_reg[fsa_pkg::QUOT_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign qbit      = !rem_diff[fsa_pkg::STEP_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        irem_next = irem_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {dividend, {fsa_pkg::FRAC_W{1'b0}}};
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[fsa_pkg::QUOT_W-2:0], qbit};
            rem_next = qbit ? rem_diff[fsa_pkg::STEP_W-1:0] : rem_shift[fsa_pkg::STEP_W-1:0];
            if (cnt_reg == fsa_pkg::CNT_W'(fsa_pkg::TIME_W - 1))
                irem_next = rem_next;
            if (cnt_reg == fsa_pkg::CNT_W'(fsa_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        irem_reg <= irem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;
    assign int_rem   = irem_reg;

endmodule

### rtl/fixed_step_accumulator_core.sv
// Top level of the fixed step accumulator: accumulate, serial divide, clamp and deliver.
`timescale 1ns / 1ps
//
//  channel | signals                                   | dir | beat moves
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, frame_time            | in  | one elapsed frame time
//  out     | out_valid, out_ready, steps_taken,        | out | step count and blend
//          | blend_fraction                            |     | fraction for one frame
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | one register write
//
//  An input beat reaches the output register in steps: the divider is loaded with the
//  saturated sum at the accept edge, the bit-serial divider runs to its done pulse, and
//  the finish state writes the result once the output is free. A new beat is taken only
//  after the finish state has returned to idle.
//  Reset is asynchronous, active low; it clears the accumulator and loads default config.
//  in_ready drops while an item is at work; a result waiting on out_ready does not block
//  the next input, only the finish of the item after it. cfg_ready is always high.
//
//  The divider computes (acc << FRAC_W) / step in one pass. Its upper quotient bits are
//  the whole steps available; if that exceeds the limit, the limit is taken and the
//  leftover (still at least one step) is dropped, so the accumulator and fraction clear.
//  Otherwise the integer remainder is the new accumulator and the low bits the fraction.

module fixed_step_accumulator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [fsa_pkg::FRAME_W-1:0] frame_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fsa_pkg::STEPS_W-1:0]    steps_taken,
    output logic [fsa_pkg::BLEND_W-1:0]    blend_fraction,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsa_pkg::CFG_DAT_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [fsa_pkg::TIME_W-1:0]      acc_reg, acc_next;
    logic                            ovld_reg, ovld_next;
    logic [fsa_pkg::STEPS_W-1:0]     steps_reg, steps_next;
    logic [fsa_pkg::BLEND_W-1:0]     blend_reg, blend_next;

    logic [fsa_pkg::STEP_W-1:0]      step_eff;
    logic [fsa_pkg::MAXS_W-1:0]      limit_eff;

    fsa_pkg::div_ctrl_t              div_ctrl;
    fsa_pkg::div_stat_t              div_stat;
    logic [fsa_pkg::QUOT_W-1:0]      quotient;
    logic [fsa_pkg::STEP_W-1:0]      int_rem;

    logic                            in_fire;
    logic                            positive;
    logic [fsa_pkg::SUM_W-1:0]       sum;
    logic [fsa_pkg::TIME_W-1:0]      acc_sat;
    logic [fsa_pkg::TIME_W-1:0]      whole_steps;
    logic                            over_limit;
    logic                            out_free;

    fsa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_eff  (step_eff),
        .limit_eff (limit_eff)
    );

    fsa_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (acc_sat),
        .divisor  (step_eff),
        .stat     (div_stat),
        .quotient (quotient),
        .int_rem  (int_rem)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !ovld_reg || out_ready;

    // Only strictly positive frame times add; the sum saturates at full scale.
    assign positive = (frame_time != '0) && !frame_time[fsa_pkg::FRAME_W-1];
    assign sum      = fsa_pkg::SUM_W'(acc_reg)
                    + (positive ? fsa_pkg::SUM_W'($unsigned(frame_time)) : '0);
    assign acc_sat  = (sum > fsa_pkg::SUM_W'(fsa_pkg::ACC_MAX))
                    ? fsa_pkg::ACC_MAX : fsa_pkg::TIME_W'(sum);

    assign div_ctrl.start = in_fire;

    assign whole_steps = quotient[fsa_pkg::QUOT_W-1:fsa_pkg::FRAC_W];
    assign over_limit  = whole_steps > fsa_pkg::TIME_W'(limit_eff);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        ovld_next  = ovld_reg;
        steps_next = steps_reg;
        blend_next = blend_reg;
        if (ovld_reg && out_ready)
            ovld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    if (over_limit)
                    begin
                        acc_next   = '0;
                        steps_next = fsa_pkg::STEPS_W'(limit_eff);
                        blend_next = '0;
                    end
                    else
                    begin
                        acc_next   = fsa_pkg::TIME_W'(int_rem);
                        steps_next = fsa_pkg::STEPS_W'(whole_steps);
                        blend_next = fsa_pkg::BLEND_W'(quotient[fsa_pkg::FRAC_W-1:0]);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        blend_reg <= blend_next;
    end

    assign out_valid      = ovld_reg;
    assign steps_taken    = steps_reg;
    assign blend_fraction = blend_reg;

endmodule
